>>> sv/brb_pkg.sv
// Shared types and constants of the byte ring buffer.
package brb_pkg;

  localparam int CNT_W     = 11;
  localparam int COUNT_W   = 4;
  localparam int BYTE_W    = 8;
  localparam int MAX_LANES = 8;
  localparam int DATA_W    = MAX_LANES * BYTE_W;
  localparam int DEPTH_DEF = 1024;
  localparam int LANES_DEF = 8;
  localparam int CAP_RESET = 1024;

  localparam logic KIND_PUSH      = 1'b0;
  localparam logic KIND_POP       = 1'b1;
  localparam logic STATUS_DONE    = 1'b0;
  localparam logic STATUS_REFUSED = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PASS0,
    ST_PASS1,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic                kind;
    logic [COUNT_W-1:0]  byte_count;
    logic [DATA_W-1:0]   push_bytes;
  } in_t;

  typedef struct packed {
    logic                status;
    logic [DATA_W-1:0]   pop_bytes;
    logic [CNT_W-1:0]    free_bytes;
    logic [CNT_W-1:0]    used_bytes;
    logic [CNT_W-1:0]    contig_free;
    logic [CNT_W-1:0]    contig_used;
    logic                is_full;
    logic                is_empty;
  } res_t;

  typedef struct packed {
    logic in_ready;
    logic cfg_ready;
    logic mem_go;
    logic mem_pass;
    logic rd_pass;
    logic rd_take;
    logic fin;
  } ctl_t;

endpackage

>>> sv/brb_ram.sv
// Generic single-port RAM with registered read data.
module brb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic                                     re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/brb_lane.sv
// One byte lane: the slot address of its byte and whether it lies past the wrap point.
module brb_lane #(
  parameter int PTR_W    = 10,
  parameter int AW       = 12,
  parameter int LANE_IDX = 0
) (
  input  logic [PTR_W-1:0]         start_i,
  input  logic [brb_pkg::CNT_W-1:0] cap_i,
  output logic [PTR_W-1:0]         addr_o,
  output logic                     wrap_o
);
  import brb_pkg::*;

  logic [AW-1:0] sum;
  logic [AW-1:0] cap_ext;

  // Start lies below the capacity and the lane offset below the count, which
  // never exceeds the capacity, so one subtraction finishes the wrap.
  always_comb begin
    cap_ext = AW'(cap_i);
    sum     = AW'(start_i) + AW'(LANE_IDX);
    wrap_o  = (sum >= cap_ext);
    addr_o  = wrap_o ? PTR_W'(sum - cap_ext) : PTR_W'(sum);
  end

endmodule

>>> sv/byte_ring_buffer_multi_unit.sv
// Top level of the byte ring buffer: control, byte lanes, banked store and result merge.
//
// A circular byte FIFO over a banked store. Each input transaction pushes or pops 0 to LANES
// bytes, all or nothing, and produces exactly one result with status, popped bytes and
// occupancy figures. An item is accepted only while the unit is idle, and no new item is
// taken before the result of the last one is loaded: the bytes of one transfer are spread
// over byte banks by address, and the part before the wrap point and the part after it each
// take their own memory pass, followed by the registered read and the result load. A pending
// result waits in the output register, and the unit stalls in its last step until that
// register is free. The capacity write empties the FIFO; the store needs no clearing pass
// after reset.
module byte_ring_buffer_multi_unit #(
  parameter int DEPTH = brb_pkg::DEPTH_DEF,
  parameter int LANES = brb_pkg::LANES_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  brb_pkg::in_t              in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output brb_pkg::res_t             out_data_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [brb_pkg::CNT_W-1:0] cfg_data_i
);
  import brb_pkg::*;

  localparam int PTR_W   = $clog2(DEPTH);
  localparam int AW      = ((PTR_W > CNT_W) ? PTR_W : CNT_W) + 1;
  localparam int BANKS   = (LANES <= 2) ? 2 : ((LANES <= 4) ? 4 : 8);
  localparam int LB      = $clog2(BANKS);
  localparam int BD      = (DEPTH + BANKS - 1) / BANKS;
  localparam int RAW     = (BD > 1) ? $clog2(BD) : 1;
  localparam int CAP_RST = (DEPTH < CAP_RESET) ? DEPTH : CAP_RESET;

  state_e               state_q, state_d;
  ctl_t                 ctl;
  logic [CNT_W-1:0]     cap_q, free_q;
  logic [PTR_W-1:0]     wp_q, rp_q;
  logic                 out_valid_q;
  res_t                 out_q;

  logic                 kind_q, ok_q;
  logic [COUNT_W-1:0]   cnt_q;
  logic [DATA_W-1:0]    data_q;
  logic [PTR_W-1:0]     start_q;
  logic [DATA_W-1:0]    pop_q;

  logic                 in_acc, cfg_acc, fin_load;
  logic [CNT_W-1:0]     used_now, cnt_in, cap_new;
  logic                 legal_in, ok_in;
  logic [PTR_W-1:0]     ptr_base, ptr_next;
  logic [AW-1:0]        step, cfg_ext;

  assign in_acc   = in_valid_i & in_ready_o;
  assign cfg_acc  = cfg_valid_i & cfg_ready_o;
  assign fin_load = ctl.fin & (~out_valid_q | out_ready_i);

  // Admission check and pointer advance for the arriving transaction.
  always_comb begin
    used_now = cap_q - free_q;
    cnt_in   = CNT_W'(in_data_i.byte_count);
    legal_in = (AW'(in_data_i.byte_count) <= AW'(LANES));
    if (in_data_i.kind == KIND_PUSH) begin
      ok_in    = legal_in && (free_q >= cnt_in);
      ptr_base = wp_q;
    end else begin
      ok_in    = legal_in && (used_now >= cnt_in);
      ptr_base = rp_q;
    end
    step     = AW'(ptr_base) + AW'(in_data_i.byte_count);
    ptr_next = (step >= AW'(cap_q)) ? PTR_W'(step - AW'(cap_q)) : PTR_W'(step);
    cfg_ext  = AW'(cfg_data_i);
    if (cfg_data_i == '0) begin
      cap_new = CNT_W'(1);
    end else if (cfg_ext > AW'(DEPTH)) begin
      cap_new = CNT_W'(DEPTH);
    end else begin
      cap_new = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= CNT_W'(CAP_RST);
      free_q <= CNT_W'(CAP_RST);
      wp_q   <= '0;
      rp_q   <= '0;
    end else if (cfg_acc) begin
      cap_q  <= cap_new;
      free_q <= cap_new;
      wp_q   <= '0;
      rp_q   <= '0;
    end else if (in_acc && ok_in) begin
      if (in_data_i.kind == KIND_PUSH) begin
        wp_q   <= ptr_next;
        free_q <= free_q - cnt_in;
      end else begin
        rp_q   <= ptr_next;
        free_q <= free_q + cnt_in;
      end
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_acc) state_d = ST_PASS0;
      ST_PASS0: state_d = ST_PASS1;
      ST_PASS1: state_d = ST_FIN;
      ST_FIN:   if (fin_load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    ctl = '0;
    unique case (state_q)
      ST_IDLE: begin
        ctl.in_ready  = 1'b1;
        ctl.cfg_ready = 1'b1;
      end
      ST_PASS0: begin
        ctl.mem_go   = 1'b1;
        ctl.mem_pass = 1'b0;
      end
      ST_PASS1: begin
        ctl.mem_go   = 1'b1;
        ctl.mem_pass = 1'b1;
        ctl.rd_pass  = 1'b0;
        ctl.rd_take  = 1'b1;
      end
      ST_FIN: begin
        ctl.rd_pass = 1'b1;
        ctl.fin     = 1'b1;
      end
      default: ctl = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o  = ctl.in_ready;
  assign cfg_ready_o = ctl.cfg_ready;

  // Byte lanes.
  logic [PTR_W-1:0]  lane_addr [LANES];
  logic              lane_wrap [LANES];
  logic              lane_en   [LANES];
  logic [LB-1:0]     lane_bank [LANES];
  logic [RAW-1:0]    lane_row  [LANES];
  logic [BYTE_W-1:0] lane_rd   [LANES];

  logic              bank_hit   [BANKS];
  logic [RAW-1:0]    bank_row   [BANKS];
  logic [BYTE_W-1:0] bank_wd    [BANKS];
  logic [BYTE_W-1:0] bank_rdata [BANKS];

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    brb_lane #(
      .PTR_W    (PTR_W),
      .AW       (AW),
      .LANE_IDX (i)
    ) u_lane (
      .start_i (start_q),
      .cap_i   (cap_q),
      .addr_o  (lane_addr[i]),
      .wrap_o  (lane_wrap[i])
    );
    assign lane_en[i]   = ok_q & (COUNT_W'(i) < cnt_q);
    assign lane_bank[i] = lane_addr[i][LB-1:0];
    assign lane_row[i]  = RAW'(AW'(lane_addr[i]) >> LB);
    assign lane_rd[i]   = bank_rdata[lane_bank[i]];
  end

  // Within one pass the lanes hold consecutive addresses, so each bank
  // serves at most one lane.
  always_comb begin
    for (int b = 0; b < BANKS; b++) begin
      bank_hit[b] = 1'b0;
      bank_row[b] = '0;
      bank_wd[b]  = '0;
      for (int i = 0; i < LANES; i++) begin
        if (lane_en[i] && (lane_wrap[i] == ctl.mem_pass) && (lane_bank[i] == LB'(b))) begin
          bank_hit[b] = 1'b1;
          bank_row[b] = lane_row[i];
          bank_wd[b]  = data_q[BYTE_W*i +: BYTE_W];
        end
      end
    end
  end

  for (genvar b = 0; b < BANKS; b++) begin : g_bank
    brb_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (BD)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (ctl.mem_go & bank_hit[b] & (kind_q == KIND_PUSH)),
      .re_i    (ctl.mem_go & bank_hit[b] & (kind_q == KIND_POP)),
      .addr_i  (bank_row[b]),
      .wdata_i (bank_wd[b]),
      .rdata_o (bank_rdata[b])
    );
  end

  // Merge: place each lane's read byte at its position in the popped word.
  logic [DATA_W-1:0] pop_cur;

  always_comb begin
    pop_cur = '0;
    for (int i = 0; i < LANES; i++) begin
      if (lane_en[i] && (kind_q == KIND_POP) && (lane_wrap[i] == ctl.rd_pass)) begin
        pop_cur[BYTE_W*i +: BYTE_W] = lane_rd[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      kind_q  <= in_data_i.kind;
      cnt_q   <= in_data_i.byte_count;
      data_q  <= in_data_i.push_bytes;
      start_q <= ptr_base;
      ok_q    <= ok_in;
      pop_q   <= '0;
    end else if (ctl.rd_take) begin
      pop_q <= pop_q | pop_cur;
    end
  end

  // Occupancy figures after the transaction.
  res_t          res;
  logic [AW-1:0] wp_x, rp_x, cap_x, cf, cu;

  always_comb begin
    wp_x  = AW'(wp_q);
    rp_x  = AW'(rp_q);
    cap_x = AW'(cap_q);
    if (wp_x == rp_x) begin
      if (free_q == '0) begin
        cf = '0;
        cu = cap_x - rp_x;
      end else begin
        cf = cap_x - wp_x;
        cu = '0;
      end
    end else begin
      cf = (wp_x > rp_x) ? (cap_x - wp_x) : (rp_x - wp_x);
      cu = (rp_x < wp_x) ? (wp_x - rp_x) : (cap_x - rp_x);
    end
    res.status      = ok_q ? STATUS_DONE : STATUS_REFUSED;
    res.pop_bytes   = pop_q | pop_cur;
    res.free_bytes  = free_q;
    res.used_bytes  = cap_q - free_q;
    res.contig_free = CNT_W'(cf);
    res.contig_used = CNT_W'(cu);
    res.is_full     = (free_q == '0);
    res.is_empty    = (free_q == cap_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_load) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_free_le_cap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q <= cap_q)
    else $error("free count exceeds capacity");

  a_ptr_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (AW'(wp_q) < AW'(cap_q)) && (AW'(rp_q) < AW'(cap_q)))
    else $error("pointer beyond capacity");

  a_coincide : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wp_q == rp_q) |-> ((free_q == '0) || (free_q == cap_q)))
    else $error("pointers coincide while partly filled");

  a_result_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_load |=> (out_valid_q && (state_q == ST_IDLE)))
    else $error("result not presented after load");

endmodule

>>> tb/sv/byte_ring_buffer_multi_unit_checker.sv
// Checker that predicts and compares the results of the byte ring buffer.
`timescale 1ns / 1ps

module byte_ring_buffer_multi_unit_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_ready_i,
  input  brb_pkg::in_t              in_data_i,
  input  logic                      out_valid_i,
  input  logic                      out_ready_i,
  input  brb_pkg::res_t             out_data_i,
  input  logic                      cfg_valid_i,
  input  logic                      cfg_ready_i,
  input  logic [brb_pkg::CNT_W-1:0] cfg_data_i,
  output int                        mismatches_o,
  output int                        outstanding_o
);
  import brb_pkg::*;

  localparam int unsigned DEPTH = DEPTH_DEF;
  localparam int unsigned LANES = LANES_DEF;

  logic [BYTE_W-1:0] ring_mem [DEPTH];
  int unsigned       rd_ptr;
  int unsigned       wr_ptr;
  int unsigned       free_slots;
  int unsigned       cap;
  res_t              due_results[$];
  int                mismatches = 0;
  int                result_idx = 0;

  function automatic int unsigned clamp_cap(logic [CNT_W-1:0] v);
    if (v == '0) return 1;
    if (v > DEPTH) return DEPTH;
    return 32'(v);
  endfunction

  function automatic int unsigned next_slot(int unsigned p);
    int unsigned s;
    s = p + 1;
    if (s >= cap) s -= cap;
    if (s >= cap) s = 0;
    return s;
  endfunction

  // Applies one transaction to the predicted ring and returns its result.
  function automatic res_t apply_transfer(in_t it);
    res_t        r;
    int unsigned p;
    int unsigned used;
    int unsigned cfree;
    int unsigned cused;
    r = '0;
    r.status = STATUS_REFUSED;
    if (it.byte_count <= LANES) begin
      if (it.kind == KIND_PUSH) begin
        if (free_slots >= it.byte_count) begin
          p = wr_ptr;
          for (int i = 0; i < int'(it.byte_count); i++) begin
            ring_mem[p] = it.push_bytes[BYTE_W*i +: BYTE_W];
            p = next_slot(p);
          end
          wr_ptr = p;
          free_slots -= it.byte_count;
          r.status = STATUS_DONE;
        end
      end else begin
        if (cap - free_slots >= it.byte_count) begin
          p = rd_ptr;
          for (int i = 0; i < int'(it.byte_count); i++) begin
            r.pop_bytes[BYTE_W*i +: BYTE_W] = ring_mem[p];
            p = next_slot(p);
          end
          rd_ptr = p;
          free_slots += it.byte_count;
          r.status = STATUS_DONE;
        end
      end
    end
    used = cap - free_slots;
    // With equal pointers the fill level tells a full ring from an empty one.
    if (wr_ptr == rd_ptr) begin
      if (free_slots == 0) begin
        cfree = 0;
        cused = cap - rd_ptr;
      end else begin
        cfree = cap - wr_ptr;
        cused = 0;
      end
    end else begin
      cfree = (wr_ptr > rd_ptr) ? cap - wr_ptr : rd_ptr - wr_ptr;
      cused = (rd_ptr < wr_ptr) ? wr_ptr - rd_ptr : cap - rd_ptr;
    end
    r.free_bytes  = CNT_W'(free_slots);
    r.used_bytes  = CNT_W'(used);
    r.contig_free = CNT_W'(cfree);
    r.contig_used = CNT_W'(cused);
    r.is_full     = (free_slots == 0);
    r.is_empty    = (used == 0);
    return r;
  endfunction

  task automatic compare_result(res_t want, res_t got);
    bit bad;
    bad = (got.status !== want.status) || (got.pop_bytes !== want.pop_bytes) ||
          (got.free_bytes !== want.free_bytes) || (got.used_bytes !== want.used_bytes) ||
          (got.contig_free !== want.contig_free) ||
          (got.contig_used !== want.contig_used) ||
          (got.is_full !== want.is_full) || (got.is_empty !== want.is_empty);
    if (bad) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("result %0d wrong: expected st %0b pop %h free %0d used %0d cf %0d cu %0d f %0b e %0b",
                 result_idx, want.status, want.pop_bytes, want.free_bytes, want.used_bytes,
                 want.contig_free, want.contig_used, want.is_full, want.is_empty);
        $display("result %0d wrong: actual   st %0b pop %h free %0d used %0d cf %0d cu %0d f %0b e %0b",
                 result_idx, got.status, got.pop_bytes, got.free_bytes, got.used_bytes,
                 got.contig_free, got.contig_used, got.is_full, got.is_empty);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap        = clamp_cap(CNT_W'(CAP_RESET));
      rd_ptr     = 0;
      wr_ptr     = 0;
      free_slots = cap;
      due_results.delete();
    end else begin
      // The older result leaves before a new transaction is queued.
      if (out_valid_i && out_ready_i) begin
        if (due_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("result %0d arrived with nothing expected", result_idx);
        end else begin
          compare_result(due_results.pop_front(), out_data_i);
        end
        result_idx++;
      end
      if (cfg_valid_i && cfg_ready_i) begin
        cap        = clamp_cap(cfg_data_i);
        rd_ptr     = 0;
        wr_ptr     = 0;
        free_slots = cap;
      end
      if (in_valid_i && in_ready_i) due_results.push_back(apply_transfer(in_data_i));
    end
    mismatches_o  <= mismatches;
    outstanding_o <= due_results.size();
  end

endmodule

>>> tb/sv/byte_ring_buffer_multi_unit_tb.sv
// Top of the byte ring buffer testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module byte_ring_buffer_multi_unit_tb;
  import brb_pkg::*;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  in_t              in_data;
  logic             out_valid;
  logic             out_ready;
  res_t             out_data;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CNT_W-1:0] cfg_data;
  int               mismatches;
  int               outstanding;
  int               send_gap_pct;
  int               recv_gap_pct;
  int               hold_req;

  byte_ring_buffer_multi_unit u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  byte_ring_buffer_multi_unit_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .in_data_i     (in_data),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .out_data_i    (out_data),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_data_i    (cfg_data),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("byte_ring_buffer_multi_unit: mismatch");
    $finish;
  end

  // Result side: random stalls, plus one long hold-off whenever one is requested.
  initial begin
    int holds_done;
    holds_done = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != holds_done) begin
        holds_done++;
        out_ready <= 1'b0;
        repeat (300) @(negedge clk);
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_gap_pct);
      end
    end
  end

  // Valid stays high between back-to-back transactions and drops only in a gap.
  task automatic send_item(input logic kind, input logic [COUNT_W-1:0] n,
                           input logic [DATA_W-1:0] bytes);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{kind, n, bytes};
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_random(input int push_pct);
    logic [COUNT_W-1:0] n;
    if ($urandom_range(0, 19) == 0) n = COUNT_W'($urandom_range(9, 15));
    else n = COUNT_W'($urandom_range(0, MAX_LANES));
    send_item(($urandom_range(0, 99) < push_pct) ? KIND_PUSH : KIND_POP, n,
              {$urandom, $urandom});
  endtask

  // The capacity changes only once every outstanding result is received and the unit has settled.
  task automatic write_capacity(input logic [CNT_W-1:0] v);
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [CNT_W-1:0] pick_capacity();
    case ($urandom_range(0, 7))
      0:       return CNT_W'(1);
      1:       return CNT_W'(2);
      2:       return CNT_W'(MAX_LANES);
      3:       return CNT_W'($urandom_range(3, 40));
      4:       return CNT_W'($urandom_range(9, 128));
      5:       return CNT_W'($urandom_range(1, DEPTH_DEF));
      6:       return CNT_W'(DEPTH_DEF);
      default: return CNT_W'($urandom_range(0, 2047));
    endcase
  endfunction

  task automatic run_phase(input int items, input int snd, input int rcv);
    int push_pct;
    send_gap_pct = snd;
    recv_gap_pct = rcv;
    push_pct = 50;
    for (int k = 0; k < items; k++) begin
      if (k == items / 2) hold_req++;
      if (k % 125 == 0) write_capacity(pick_capacity());
      if (k % 50 == 0) push_pct = 10 + 20 * $urandom_range(0, 4);
      send_random(push_pct);
    end
  endtask

  initial begin
    in_valid     = 1'b0;
    in_data      = '0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    rst_n        = 1'b0;
    hold_req     = 0;
    send_gap_pct = 10;
    recv_gap_pct = 78;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Empty ring at the reset capacity: zero counts, refusals, oversize counts.
    send_item(KIND_POP, 4'd0, '0);
    send_item(KIND_POP, 4'd1, '0);
    send_item(KIND_PUSH, 4'd0, '1);
    send_item(KIND_PUSH, 4'd15, '1);
    send_item(KIND_POP, 4'd9, '0);
    send_item(KIND_PUSH, 4'd8, '1);
    send_item(KIND_PUSH, 4'd8, 64'h0123_4567_89AB_CDEF);
    send_item(KIND_PUSH, 4'd3, 64'hDEAD_BEEF_00A5_5A3C);
    send_item(KIND_POP, 4'd8, '0);
    send_item(KIND_POP, 4'd8, '0);
    send_item(KIND_POP, 4'd4, '0);
    send_item(KIND_POP, 4'd3, '0);

    // A five-slot ring goes full and empty with coinciding pointers and wraps.
    write_capacity(CNT_W'(5));
    send_item(KIND_PUSH, 4'd5, 64'h1122_3344_5566_7788);
    send_item(KIND_PUSH, 4'd1, 64'h99);
    send_item(KIND_POP, 4'd2, '0);
    send_item(KIND_PUSH, 4'd2, 64'hAABB);
    send_item(KIND_POP, 4'd5, '0);

    // A zero capacity acts as one slot; an oversize one saturates.
    write_capacity('0);
    send_item(KIND_PUSH, 4'd1, 64'hC3);
    send_item(KIND_POP, 4'd1, '0);
    write_capacity('1);
    send_item(KIND_PUSH, 4'd8, {$urandom, $urandom});
    send_item(KIND_POP, 4'd8, '0);

    run_phase(450, 10, 78);
    run_phase(450, 78, 10);
    run_phase(450, 0, 0);

    // Fill the full-size ring to the top, then drain it again.
    write_capacity(CNT_W'(DEPTH_DEF));
    for (int k = 0; k < 140; k++) send_item(KIND_PUSH, 4'd8, {$urandom, $urandom});
    for (int k = 0; k < 140; k++) send_item(KIND_POP, 4'd8, '0);

    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (mismatches == 0) begin
      $display("byte_ring_buffer_multi_unit: match");
    end else begin
      $display("byte_ring_buffer_multi_unit: mismatch");
    end
    $finish;
  end

endmodule
